/* rtl/adjacency_matrix_dfs_unit_defines.svh */
// Assertion macros shared by the checker of the adjacency matrix search unit.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ADJACENCY_MATRIX_DFS_UNIT_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define AMDFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define AMDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/amdfs_pkg.sv */
// Package for the adjacency matrix depth-first search unit.
// Holds sizes, request codes, the edge command struct and the count mask function.
// No dependencies.
package amdfs_pkg;

    localparam int VERTICES = 16;
    localparam int VTX_W    = $clog2(VERTICES);
    localparam int DEPTH_W  = $clog2(VERTICES) + 1;
    localparam int COUNT_W  = 5;
    localparam int REQ_W    = 2;

    typedef logic [VTX_W-1:0]    vertex_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [VERTICES-1:0] row_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [REQ_W-1:0]    req_type_t;

    localparam req_type_t REQ_ADD_EDGE = 2'd0;
    localparam req_type_t REQ_SEARCH   = 2'd1;
    localparam req_type_t REQ_CLEAR    = 2'd2;

    localparam count_t COUNT_RESET = count_t'(VERTICES);

    typedef struct packed {
        logic    add;
        logic    clear;
        vertex_t first;
        vertex_t second;
    } edge_cmd_t;

    // Vertices in use: a count of zero acts as one, counts above VERTICES saturate.
    function automatic row_t count_mask(input count_t count);
        count_t eff;
        row_t   mask;
        eff = count;
        if (count == '0) begin
            eff = count_t'(1);
        end
        else if (count > count_t'(VERTICES)) begin
            eff = count_t'(VERTICES);
        end
        for (int i = 0; i < VERTICES; i++) begin
            mask[i] = (count_t'(i) < eff);
        end
        return mask;
    endfunction

endpackage

/* rtl/amdfs_if.sv */
// Handshake channel interfaces of the adjacency matrix search unit.
// Depends on amdfs_pkg for the payload types.
interface amdfs_req_if;
    logic                valid;
    logic                ready;
    amdfs_pkg::req_type_t req_type;
    amdfs_pkg::vertex_t  first_vertex;
    amdfs_pkg::vertex_t  second_vertex;

    modport source (output valid, req_type, first_vertex, second_vertex, input ready);
    modport sink   (input valid, req_type, first_vertex, second_vertex, output ready);
endinterface

interface amdfs_visit_if;
    logic               valid;
    logic               ready;
    amdfs_pkg::vertex_t visited_vertex;
    logic               last_visit;

    modport source (output valid, visited_vertex, last_visit, input ready);
    modport sink   (input valid, visited_vertex, last_visit, output ready);
endinterface

interface amdfs_cfg_if;
    logic              valid;
    logic              ready;
    amdfs_pkg::count_t vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

/* rtl/adjacency_matrix_dfs_unit.sv */
// Top level of the adjacency matrix depth-first search unit: sequencer, stack and output slot.
// Depends on amdfs_pkg, the channel interfaces, amdfs_edge_rows and amdfs_next_pick.
//
//  Channel  Dir  Beat contents
//  req      in   req_type, first_vertex, second_vertex
//  visit    out  visited_vertex, last_visit
//  cfg      in   vertex_count
//
// Add-edge and clear requests are taken in idle, and the unit stays idle. A search does one stack
// step per matrix row lookup, one push or one pop, until the stack empties; then the last
// found vertex is flushed to the output slot and req is ready again.
// The sequencer holds one found vertex back until it knows whether it is the last one.
// A full output slot that is not drained stalls the search; req is not ready meanwhile.
// Reset clears the matrix, the marks and the stack depth, and sets vertex_count to 16.
module adjacency_matrix_dfs_unit (
    input  logic          clk,
    input  logic          rst_n,
    amdfs_req_if.sink     req,
    amdfs_visit_if.source visit,
    amdfs_cfg_if.sink     cfg
);
    import amdfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FLUSH
    } state_t;

    state_t    state_reg,     state_next;
    depth_t    depth_reg,     depth_next;
    row_t      visited_reg,   visited_next;
    logic      out_valid_reg, out_valid_next;
    count_t    count_reg;
    vertex_t   pend_reg,      pend_next;
    vertex_t   out_vertex_reg;
    logic      out_last_reg;
    vertex_t   stack_reg [VERTICES];

    edge_cmd_t edge_cmd;
    row_t      row;
    row_t      in_use;
    vertex_t   top_vertex;
    logic      found;
    vertex_t   next_vertex;
    row_t      next_onehot;
    logic      req_fire;
    logic      slot_free;
    logic      out_load;
    logic      out_last_in;
    logic      stack_we;
    vertex_t   stack_wa;
    vertex_t   stack_wd;
    depth_t    depth_dec;

    assign req.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign visit.valid          = out_valid_reg;
    assign visit.visited_vertex = out_vertex_reg;
    assign visit.last_visit     = out_last_reg;

    assign req_fire  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || visit.ready;
    assign in_use    = count_mask(count_reg);
    assign depth_dec = depth_reg - depth_t'(1);
    assign top_vertex = stack_reg[depth_dec[VTX_W-1:0]];

    always_comb
    begin
        edge_cmd.add    = req_fire && (req.req_type == REQ_ADD_EDGE);
        edge_cmd.clear  = req_fire && (req.req_type == REQ_CLEAR);
        edge_cmd.first  = req.first_vertex;
        edge_cmd.second = req.second_vertex;
    end

    amdfs_edge_rows u_edge_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (edge_cmd),
        .rd_addr (top_vertex),
        .rd_row  (row)
    );

    amdfs_next_pick u_next_pick (
        .row         (row),
        .in_use      (in_use),
        .visited     (visited_reg),
        .found       (found),
        .next_vertex (next_vertex),
        .next_onehot (next_onehot)
    );

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        visited_next = visited_reg;
        pend_next    = pend_reg;
        out_load     = 1'b0;
        out_last_in  = 1'b0;
        stack_we     = 1'b0;
        stack_wa     = depth_reg[VTX_W-1:0];
        stack_wd     = next_vertex;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_SEARCH))
                begin
                    visited_next = row_t'(1);
                    depth_next   = depth_t'(1);
                    pend_next    = '0;
                    stack_we     = 1'b1;
                    stack_wa     = '0;
                    stack_wd     = '0;
                    state_next   = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!found)
                begin
                    depth_next = depth_dec;
                    if (depth_reg == depth_t'(1))
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else if (slot_free)
                begin
                    out_load     = 1'b1;
                    pend_next    = next_vertex;
                    visited_next = visited_reg | next_onehot;
                    if (depth_reg < depth_t'(VERTICES))
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + depth_t'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    out_last_in  = 1'b1;
                    visited_next = '0;
                    depth_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !visit.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            visited_reg    <= '0;
            out_valid_reg  <= 1'b0;
            count_reg      <= COUNT_RESET;
            pend_reg       <= '0;
            out_vertex_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (out_load)
            begin
                out_vertex_reg <= pend_reg;
                out_last_reg   <= out_last_in;
            end
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.vertex_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_reg[stack_wa] <= stack_wd;
        end
    end

endmodule

/* rtl/amdfs_edge_rows.sv */
// Bit adjacency matrix storage with symmetric edge insert, full clear and one row read.
// Depends on amdfs_pkg.
module amdfs_edge_rows (
    input  logic                 clk,
    input  logic                 rst_n,
    input  amdfs_pkg::edge_cmd_t cmd,
    input  amdfs_pkg::vertex_t   rd_addr,
    output amdfs_pkg::row_t      rd_row
);
    import amdfs_pkg::*;

    row_t rows_reg [VERTICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VERTICES; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < VERTICES; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (cmd.add)
        begin
            for (int i = 0; i < VERTICES; i++)
            begin
                rows_reg[i] <= rows_reg[i]
                    | ((vertex_t'(i) == cmd.first)  ? (row_t'(1) << cmd.second) : '0)
                    | ((vertex_t'(i) == cmd.second) ? (row_t'(1) << cmd.first)  : '0);
            end
        end
    end

    assign rd_row = rows_reg[rd_addr];

endmodule

/* rtl/amdfs_next_pick.sv */
// Combinational step unit: masks a matrix row and finds the lowest unvisited neighbor.
// Depends on amdfs_pkg.
module amdfs_next_pick (
    input  amdfs_pkg::row_t    row,
    input  amdfs_pkg::row_t    in_use,
    input  amdfs_pkg::row_t    visited,
    output logic               found,
    output amdfs_pkg::vertex_t next_vertex,
    output amdfs_pkg::row_t    next_onehot
);
    import amdfs_pkg::*;

    row_t cand;

    always_comb
    begin
        cand        = row & in_use & ~visited;
        found       = |cand;
        next_vertex = '0;
        for (int i = VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                next_vertex = vertex_t'(i);
            end
        end
        next_onehot = cand & (~cand + row_t'(1));
    end

endmodule

/* rtl/amdfs_checker.sv */
// Port-level checker for the adjacency matrix search unit, bound to the top level.
// Depends on amdfs_pkg and adjacency_matrix_dfs_unit_defines.svh.
`include "adjacency_matrix_dfs_unit_defines.svh"

module amdfs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input amdfs_pkg::req_type_t req_type,
    input logic                 visit_valid,
    input logic                 visit_ready,
    input amdfs_pkg::vertex_t   visited_vertex,
    input logic                 last_visit
);
    import amdfs_pkg::*;

    `AMDFS_ASSERT_NEXT(a_visit_hold, clk, rst_n, visit_valid && !visit_ready,
        visit_valid && $stable(visited_vertex) && $stable(last_visit),
        "Stalled visit beat changed or dropped.")

    `AMDFS_ASSERT_NEXT(a_search_busy, clk, rst_n,
        req_valid && req_ready && (req_type == REQ_SEARCH), !req_ready,
        "Request channel ready right after a search was accepted.")

    `AMDFS_ASSERT_NOW(a_idle_only_last, clk, rst_n, req_ready,
        !visit_valid || last_visit,
        "Unit idle while a non-final visit beat is pending.")

endmodule

bind adjacency_matrix_dfs_unit amdfs_checker u_amdfs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_type       (req.req_type),
    .visit_valid    (visit.valid),
    .visit_ready    (visit.ready),
    .visited_vertex (visit.visited_vertex),
    .last_visit     (visit.last_visit)
);
